@@ src/wgme_pkg.sv @@
// Shared types and constants for the weighted graph merge engine.
package wgme_pkg;

  // Command codes
  localparam logic [2:0] CMD_SET   = 3'd0;
  localparam logic [2:0] CMD_FLIP  = 3'd1;
  localparam logic [2:0] CMD_READ  = 3'd2;
  localparam logic [2:0] CMD_MERGE = 3'd3;
  localparam logic [2:0] CMD_UNDO  = 3'd4;

  localparam logic [20:0] COST_MAX = 21'h1FFFFF;
  localparam logic [6:0]  ACTIVE_RESET = 7'd64;

  typedef struct packed {
    logic [2:0]         command;
    logic [5:0]         node_u;
    logic [5:0]         node_v;
    logic signed [15:0] weight_in;
  } req_t;

  typedef struct packed {
    logic signed [15:0] weight_out;
    logic               is_connected;
    logic [20:0]        merge_cost;
    logic               v_removed;
  } rsp_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_UV,
    RD_COL
  } rd_sel_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_CLEAR,
    WR_SET_UV,
    WR_SET_VU,
    WR_FLIP_UV,
    WR_FLIP_VU,
    WR_COL_IU,
    WR_COL_UI
  } wr_sel_t;

  typedef struct packed {
    logic    ld;
    rd_sel_t rd;
    wr_sel_t wr;
    logic    clr_inc;
    logic    i_inc;
    logic    cost_acc;
    logic    mark;
    logic    out_ld;
  } ctrl_t;

  typedef struct packed {
    logic       clr_last;
    logic       bad;
    logic [2:0] command;
    logic       i_done;
    logic       i_skip;
  } stat_t;

endpackage

@@ src/weighted_graph_merge_engine.sv @@
// Top level of the weighted graph merge engine.
// Usage:
//   A request (req) is taken at a rising edge with start high and busy low.
//   It names a command and a vertex pair; set, flip, read, merge, undo merge.
//   Each request yields one result on rsp, marked by done for one cycle;
//   the receiver cannot stall, so the result must be taken in that cycle.
//   cfg_we/cfg_data write active_nodes; write it only while busy is low.
// Sequencing (request to done):
//   read goes straight to the result read; set writes both pair entries;
//   flip reads the pair and writes both back negated; merge and undo walk
//   the vertices below active_nodes, skipping u, v and removed ones. The
//   weight memory has a single write port, so every walked vertex needs
//   one read and two mirrored writes. Throughput is one request at a time;
//   the next may start in the cycle done is high.
// Reset:
//   rst clears all merge marks and sets active_nodes to 64, then the weight
//   memory is swept to -1, one entry a cycle, over all 2^(2*ceil(log2 MAX_NODES))
//   entries (4096 by default) with busy high.
module weighted_graph_merge_engine import wgme_pkg::*; #(
  parameter int MAX_NODES   = 64,
  parameter int WEIGHT_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  req_t       req,
  output logic       done,
  output rsp_t       rsp,
  input  logic       cfg_we,
  input  logic [6:0] cfg_data
);

  ctrl_t ctl;
  stat_t sts;

  wgme_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .sts   (sts),
    .ctl   (ctl)
  );

  wgme_dp #(
    .MAX_NODES   (MAX_NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req),
    .ctl      (ctl),
    .sts      (sts),
    .rsp      (rsp)
  );

  // An accepted request keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("request accepted but block not busy");

  // A result appears only once the block is free again
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result strobe while busy");

  // Never two results back to back
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe repeated");

endmodule

@@ src/wgme_dp.sv @@
// Datapath: weight memory, merge marks, column walk arithmetic and result register.
module wgme_dp import wgme_pkg::*; #(
  parameter int MAX_NODES   = 64,
  parameter int WEIGHT_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [6:0] cfg_data,
  input  req_t       req,
  input  ctrl_t      ctl,
  output stat_t      sts,
  output rsp_t       rsp
);

  localparam int NW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int IW  = NW + 1;
  localparam int AW  = 2 * NW;
  localparam int NP2 = 1 << NW;
  localparam int WB  = WEIGHT_BITS;

  function automatic logic [WB-1:0] sat_w(input logic signed [33:0] x);
    logic signed [33:0] hi;
    logic signed [33:0] lo;
    hi = (34'sd1 <<< (WB - 1)) - 34'sd1;
    lo = -hi - 34'sd1;
    if (x > hi) sat_w = hi[WB-1:0];
    else if (x < lo) sat_w = lo[WB-1:0];
    else sat_w = x[WB-1:0];
  endfunction

  function automatic logic [15:0] sat16(input logic signed [33:0] x);
    if (x > 34'sd32767) sat16 = 16'h7FFF;
    else if (x < -34'sd32768) sat16 = 16'h8000;
    else sat16 = x[15:0];
  endfunction

  function automatic logic [WB:0] mag(input logic signed [WB-1:0] x);
    logic signed [WB:0] e;
    e = (WB+1)'(x);
    mag = (x < 0) ? (WB+1)'(0) - e : e;
  endfunction

  // Memory and registers
  logic [WB-1:0]  mem [0:(1<<AW)-1];
  logic [WB-1:0]  rd_a;
  logic [WB-1:0]  rd_b;
  logic [AW-1:0]  clr_cnt;
  logic [NP2-1:0] removed;
  logic [6:0]     active_nodes;
  logic [2:0]     cmd;
  logic [NW-1:0]  u;
  logic [NW-1:0]  v;
  logic [15:0]    win;
  logic           bad;
  logic [IW-1:0]  i_cnt;
  logic [20:0]    cost;
  logic [WB-1:0]  new_q;

  logic [NW-1:0]  ii;
  logic [31:0]    n_lim;
  logic [AW-1:0]  ra;
  logic [AW-1:0]  rb;
  logic           we;
  logic [AW-1:0]  wa;
  logic [WB-1:0]  wd;
  logic [WB-1:0]  new_w;
  logic [WB-1:0]  ca;
  logic [WB-1:0]  cb;
  logic [WB:0]    ma;
  logic [WB:0]    mb;
  logic [WB:0]    pmin;
  logic           sdiff;
  logic [34:0]    csum;

  assign ii    = i_cnt[NW-1:0];
  assign n_lim = (32'(active_nodes) > 32'(MAX_NODES)) ? 32'(MAX_NODES) : 32'(active_nodes);

  // Status toward the controller
  assign sts.clr_last = &clr_cnt;
  assign sts.bad      = bad;
  assign sts.command  = cmd;
  assign sts.i_done   = 32'(i_cnt) >= n_lim;
  assign sts.i_skip   = (ii == u) || (ii == v) || removed[ii];

  // Column update value
  always_comb begin
    if (cmd == CMD_MERGE) begin
      new_w = sat_w(34'(signed'(rd_a)) + 34'(signed'(rd_b)));
    end else begin
      new_w = sat_w(34'(signed'(rd_a)) - 34'(signed'(rd_b)));
    end
  end

  // Pick cost operands: old pair on merge, new pair on undo
  always_comb begin
    if (cmd == CMD_MERGE) begin
      ca = rd_a;
      cb = rd_b;
    end else begin
      ca = new_q;
      cb = (u == v) ? new_q : rd_b;
    end
    ma    = mag(ca);
    mb    = mag(cb);
    pmin  = (ma < mb) ? ma : mb;
    sdiff = ({signed'(ca) > 0, signed'(ca) < 0} != {signed'(cb) > 0, signed'(cb) < 0});
    csum  = 35'(cost) + (sdiff ? 35'(pmin) : 35'd0);
  end

  // Read address select
  always_comb begin
    case (ctl.rd)
      RD_COL: begin
        ra = {ii, u};
        rb = {ii, v};
      end
      default: begin
        ra = {u, v};
        rb = {v, u};
      end
    endcase
  end

  // Write port select
  always_comb begin
    we = 1'b1;
    wa = '0;
    wd = '0;
    case (ctl.wr)
      WR_CLEAR: begin
        wa = clr_cnt;
        wd = '1;
      end
      WR_SET_UV: begin
        wa = {u, v};
        wd = sat_w(34'(signed'(win)));
      end
      WR_SET_VU: begin
        wa = {v, u};
        wd = sat_w(34'(signed'(win)));
      end
      WR_FLIP_UV: begin
        wa = {u, v};
        wd = sat_w(-34'(signed'(rd_a)));
      end
      WR_FLIP_VU: begin
        wa = {v, u};
        wd = sat_w(-34'(signed'(rd_b)));
      end
      WR_COL_IU: begin
        wa = {ii, u};
        wd = new_w;
      end
      WR_COL_UI: begin
        wa = {u, ii};
        wd = new_q;
      end
      default: we = 1'b0;
    endcase
  end

  // Weight memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (ctl.rd != RD_NONE) begin
      rd_a <= mem[ra];
      rd_b <= mem[rb];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt      <= '0;
      removed      <= '0;
      active_nodes <= ACTIVE_RESET;
      i_cnt        <= '0;
      cost         <= '0;
    end else begin
      if (cfg_we) begin
        active_nodes <= cfg_data;
      end
      if (ctl.clr_inc) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (ctl.ld) begin
        i_cnt <= '0;
        cost  <= '0;
      end else begin
        if (ctl.i_inc) begin
          i_cnt <= i_cnt + IW'(1);
        end
        if (ctl.cost_acc) begin
          cost <= (csum > 35'(COST_MAX)) ? COST_MAX : csum[20:0];
        end
      end
      if (ctl.mark) begin
        removed[v] <= (cmd == CMD_MERGE);
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    if (ctl.ld) begin
      cmd <= req.command;
      u   <= NW'(req.node_u);
      v   <= NW'(req.node_v);
      win <= req.weight_in;
      bad <= (32'(req.node_u) >= 32'(MAX_NODES)) || (32'(req.node_v) >= 32'(MAX_NODES));
    end
    if (ctl.wr == WR_COL_IU) begin
      new_q <= new_w;
    end
    if (ctl.out_ld) begin
      if (bad) begin
        rsp <= '0;
      end else begin
        rsp.weight_out   <= sat16(34'(signed'(rd_a)));
        rsp.is_connected <= signed'(rd_a) > 0;
        rsp.merge_cost   <= cost;
        rsp.v_removed    <= removed[v];
      end
    end
  end

endmodule

@@ src/wgme_ctrl.sv @@
// Controller: sequences clearing, pair commands and the column walk.
module wgme_ctrl import wgme_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  output logic  busy,
  output logic  done,
  input  stat_t sts,
  output ctrl_t ctl
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_SET_UV,
    ST_SET_VU,
    ST_FLIP_RD,
    ST_FLIP_WA,
    ST_FLIP_WB,
    ST_COL_CHK,
    ST_COL_WA,
    ST_COL_WB,
    ST_FIN,
    ST_OUT_RD,
    ST_OUT
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != ST_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_next   = state;
    ctl          = '0;
    ctl.rd       = RD_NONE;
    ctl.wr       = WR_NONE;
    unique case (state)
      ST_CLEAR: begin
        ctl.wr      = WR_CLEAR;
        ctl.clr_inc = 1'b1;
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          ctl.ld     = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts.bad) begin
          state_next = ST_OUT_RD;
        end else begin
          unique case (sts.command) inside
            CMD_SET:             state_next = ST_SET_UV;
            CMD_FLIP:            state_next = ST_FLIP_RD;
            CMD_MERGE, CMD_UNDO: state_next = ST_COL_CHK;
            default:             state_next = ST_OUT_RD;
          endcase
        end
      end
      ST_SET_UV: begin
        ctl.wr     = WR_SET_UV;
        state_next = ST_SET_VU;
      end
      ST_SET_VU: begin
        ctl.wr     = WR_SET_VU;
        state_next = ST_OUT_RD;
      end
      ST_FLIP_RD: begin
        ctl.rd     = RD_UV;
        state_next = ST_FLIP_WA;
      end
      ST_FLIP_WA: begin
        ctl.wr     = WR_FLIP_UV;
        state_next = ST_FLIP_WB;
      end
      ST_FLIP_WB: begin
        ctl.wr     = WR_FLIP_VU;
        state_next = ST_OUT_RD;
      end
      ST_COL_CHK: begin
        if (sts.i_done) begin
          state_next = ST_FIN;
        end else if (sts.i_skip) begin
          ctl.i_inc = 1'b1;
        end else begin
          ctl.rd     = RD_COL;
          state_next = ST_COL_WA;
        end
      end
      ST_COL_WA: begin
        ctl.wr     = WR_COL_IU;
        state_next = ST_COL_WB;
      end
      ST_COL_WB: begin
        ctl.wr       = WR_COL_UI;
        ctl.cost_acc = 1'b1;
        ctl.i_inc    = 1'b1;
        state_next   = ST_COL_CHK;
      end
      ST_FIN: begin
        ctl.mark   = 1'b1;
        state_next = ST_OUT_RD;
      end
      ST_OUT_RD: begin
        ctl.rd     = RD_UV;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        ctl.out_ld = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Hold state and the result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_OUT);
    end
  end

endmodule
